// File: hdl/mips3_dec_pkg.sv
package mips3_dec_pkg;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_RESERVED = 2'd1,
    FAULT_COP_UNUS = 2'd2
  } fault_e;

  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_COP0    = 6'h10;
  localparam logic [5:0] OPC_COP1    = 6'h11;
  localparam logic [5:0] OPC_COP2    = 6'h12;
  localparam logic [5:0] OPC_COP3    = 6'h13;

  localparam logic [4:0] RS_COP0_CO  = 5'h10;
  localparam logic [4:0] RS_COP1_BC  = 5'h08;

  localparam logic [0:0] CFG_COP2 = 1'b0;
  localparam logic [0:0] CFG_COP3 = 1'b1;

  localparam logic [7:0] OP_COP2_BASE = 8'd43;
  localparam logic [7:0] OP_COP1_CMP  = 8'd22;

  typedef struct packed {
    logic [31:0] instruction_word;
  } dec_in_t;

  typedef struct packed {
    logic [7:0]  operation;
    logic [1:0]  fault_kind;
    logic [1:0]  fault_unit;
    logic        illegal_quiet;
    logic [4:0]  source_reg;
    logic [4:0]  target_reg;
    logic [4:0]  dest_reg;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
    logic [25:0] jump_target;
  } dec_out_t;

  function automatic logic [7:0] primary_op(input logic [5:0] c);
    logic [7:0] r;
    unique case (c)
      6'h20: r = 8'd51; 6'h24: r = 8'd52; 6'h37: r = 8'd53; 6'h1A: r = 8'd54;
      6'h1B: r = 8'd55; 6'h21: r = 8'd56; 6'h25: r = 8'd57; 6'h30: r = 8'd58;
      6'h34: r = 8'd59; 6'h23: r = 8'd60; 6'h22: r = 8'd61; 6'h26: r = 8'd62;
      6'h27: r = 8'd63; 6'h28: r = 8'd64; 6'h38: r = 8'd65; 6'h3C: r = 8'd66;
      6'h3F: r = 8'd67; 6'h2C: r = 8'd68; 6'h2D: r = 8'd69; 6'h29: r = 8'd70;
      6'h2B: r = 8'd71; 6'h2A: r = 8'd72; 6'h2E: r = 8'd73; 6'h08: r = 8'd74;
      6'h09: r = 8'd75; 6'h0C: r = 8'd76; 6'h18: r = 8'd77; 6'h19: r = 8'd78;
      6'h0F: r = 8'd79; 6'h0D: r = 8'd80; 6'h0A: r = 8'd81; 6'h0B: r = 8'd82;
      6'h0E: r = 8'd83; 6'h02: r = 8'd84; 6'h03: r = 8'd85; 6'h04: r = 8'd86;
      6'h14: r = 8'd87; 6'h07: r = 8'd88; 6'h17: r = 8'd89; 6'h06: r = 8'd90;
      6'h16: r = 8'd91; 6'h05: r = 8'd92; 6'h15: r = 8'd93; 6'h2F: r = 8'd94;
      6'h35: r = 8'd95; 6'h31: r = 8'd96; 6'h3D: r = 8'd97; 6'h39: r = 8'd98;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] regimm_op(input logic [4:0] c);
    logic [7:0] r;
    unique case (c)
      5'h01: r = 8'd99;  5'h11: r = 8'd100; 5'h13: r = 8'd101; 5'h03: r = 8'd102;
      5'h00: r = 8'd103; 5'h10: r = 8'd104; 5'h12: r = 8'd105; 5'h02: r = 8'd106;
      5'h0C: r = 8'd107; 5'h08: r = 8'd108; 5'h09: r = 8'd109; 5'h0A: r = 8'd110;
      5'h0B: r = 8'd111; 5'h0E: r = 8'd112;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] special_op(input logic [5:0] c);
    logic [7:0] r;
    unique case (c)
      6'h20: r = 8'd113; 6'h21: r = 8'd114; 6'h24: r = 8'd115; 6'h2C: r = 8'd116;
      6'h2D: r = 8'd117; 6'h2E: r = 8'd118; 6'h2F: r = 8'd119; 6'h27: r = 8'd120;
      6'h25: r = 8'd121; 6'h2A: r = 8'd122; 6'h2B: r = 8'd123; 6'h22: r = 8'd124;
      6'h23: r = 8'd125; 6'h26: r = 8'd126; 6'h38: r = 8'd127; 6'h14: r = 8'd128;
      6'h3C: r = 8'd129; 6'h3B: r = 8'd130; 6'h17: r = 8'd131; 6'h3F: r = 8'd132;
      6'h3A: r = 8'd133; 6'h16: r = 8'd134; 6'h3E: r = 8'd135; 6'h00: r = 8'd136;
      6'h04: r = 8'd137; 6'h03: r = 8'd138; 6'h07: r = 8'd139; 6'h02: r = 8'd140;
      6'h06: r = 8'd141; 6'h1E: r = 8'd142; 6'h1F: r = 8'd143; 6'h1A: r = 8'd144;
      6'h1B: r = 8'd145; 6'h1C: r = 8'd146; 6'h1D: r = 8'd147; 6'h18: r = 8'd148;
      6'h19: r = 8'd149; 6'h09: r = 8'd150; 6'h08: r = 8'd151; 6'h34: r = 8'd152;
      6'h30: r = 8'd153; 6'h31: r = 8'd154; 6'h32: r = 8'd155; 6'h33: r = 8'd156;
      6'h36: r = 8'd157; 6'h10: r = 8'd158; 6'h12: r = 8'd159; 6'h11: r = 8'd160;
      6'h13: r = 8'd161; 6'h0D: r = 8'd162; 6'h0F: r = 8'd163; 6'h0C: r = 8'd164;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cop0_fn_op(input logic [5:0] c);
    logic [7:0] r;
    unique case (c)
      6'h18: r = 8'd1; 6'h08: r = 8'd2; 6'h01: r = 8'd3; 6'h02: r = 8'd4;
      6'h06: r = 8'd5;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cop0_rs_op(input logic [4:0] c);
    logic [7:0] r;
    unique case (c)
      5'h01: r = 8'd6; 5'h05: r = 8'd7; 5'h00: r = 8'd8; 5'h04: r = 8'd9;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cop1_bc_op(input logic [4:0] c);
    logic [7:0] r;
    unique case (c)
      5'h00: r = 8'd10; 5'h02: r = 8'd11; 5'h01: r = 8'd12; 5'h03: r = 8'd13;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cop1_rs_op(input logic [4:0] c);
    logic [7:0] r;
    unique case (c)
      5'h02: r = 8'd14; 5'h03: r = 8'd15; 5'h06: r = 8'd16; 5'h07: r = 8'd17;
      5'h00: r = 8'd18; 5'h01: r = 8'd19; 5'h04: r = 8'd20; 5'h05: r = 8'd21;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cop1_fn_op(input logic [5:0] c);
    logic [7:0] r;
    unique case (c)
      6'h05: r = 8'd23; 6'h00: r = 8'd24; 6'h03: r = 8'd25; 6'h06: r = 8'd26;
      6'h02: r = 8'd27; 6'h07: r = 8'd28; 6'h04: r = 8'd29; 6'h01: r = 8'd30;
      6'h0A: r = 8'd31; 6'h0E: r = 8'd32; 6'h21: r = 8'd33; 6'h25: r = 8'd34;
      6'h20: r = 8'd35; 6'h24: r = 8'd36; 6'h0B: r = 8'd37; 6'h0F: r = 8'd38;
      6'h08: r = 8'd39; 6'h0C: r = 8'd40; 6'h09: r = 8'd41; 6'h0D: r = 8'd42;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/mips3_dec_if.sv
interface mips3_dec_in_if;
  logic                     valid;
  logic                     ready;
  mips3_dec_pkg::dec_in_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mips3_dec_out_if;
  logic                     valid;
  logic                     ready;
  mips3_dec_pkg::dec_out_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/mips3_dec_logic.sv
// Combinational decode of one instruction word
module mips3_dec_logic (
  input  logic [31:0]            word_i,
  input  logic                   cop2_usable_i,
  input  logic                   cop3_usable_i,
  output mips3_dec_pkg::dec_out_t res_o
);
  logic [5:0] prim;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [5:0] fn;
  logic [7:0] op;
  logic [1:0] fault;
  logic [1:0] unit;
  logic       quiet;

  assign prim = word_i[31:26];
  assign rs   = word_i[25:21];
  assign rt   = word_i[20:16];
  assign fn   = word_i[5:0];

  // opcode tree
  always_comb begin
    op    = 8'd0;
    fault = mips3_dec_pkg::FAULT_NONE;
    unit  = 2'd0;
    quiet = 1'b0;
    unique case (prim)
      mips3_dec_pkg::OPC_SPECIAL: begin
        op = mips3_dec_pkg::special_op(fn);
        if (op == 8'd0) fault = mips3_dec_pkg::FAULT_RESERVED;
      end
      mips3_dec_pkg::OPC_REGIMM: begin
        op = mips3_dec_pkg::regimm_op(rt);
        if (op == 8'd0) fault = mips3_dec_pkg::FAULT_RESERVED;
      end
      mips3_dec_pkg::OPC_COP0: begin
        if (rs == mips3_dec_pkg::RS_COP0_CO) begin
          op = mips3_dec_pkg::cop0_fn_op(fn);
          if (op == 8'd0) quiet = 1'b1;
        end else begin
          op = mips3_dec_pkg::cop0_rs_op(rs);
          if (op == 8'd0) fault = mips3_dec_pkg::FAULT_RESERVED;
        end
      end
      mips3_dec_pkg::OPC_COP1: begin
        if (rs == mips3_dec_pkg::RS_COP1_BC) begin
          op = mips3_dec_pkg::cop1_bc_op(rt);
          if (op == 8'd0) fault = mips3_dec_pkg::FAULT_RESERVED;
        end else if (mips3_dec_pkg::cop1_rs_op(rs) != 8'd0) begin
          op = mips3_dec_pkg::cop1_rs_op(rs);
        end else if (fn[5:4] == 2'b11) begin
          op = mips3_dec_pkg::OP_COP1_CMP;
        end else begin
          op = mips3_dec_pkg::cop1_fn_op(fn);
          if (op == 8'd0) quiet = 1'b1;
        end
      end
      mips3_dec_pkg::OPC_COP2: begin
        if (!rs[4] && !rs[3]) begin
          op = mips3_dec_pkg::OP_COP2_BASE + {5'd0, rs[2:0]};
        end else if (cop2_usable_i) begin
          fault = mips3_dec_pkg::FAULT_RESERVED;
        end else begin
          fault = mips3_dec_pkg::FAULT_COP_UNUS;
          unit  = 2'd2;
        end
      end
      mips3_dec_pkg::OPC_COP3: begin
        if (rs == 5'd0 || cop3_usable_i) begin
          fault = mips3_dec_pkg::FAULT_RESERVED;
        end else begin
          fault = mips3_dec_pkg::FAULT_COP_UNUS;
          unit  = 2'd3;
        end
      end
      default: begin
        op = mips3_dec_pkg::primary_op(prim);
        if (op == 8'd0) fault = mips3_dec_pkg::FAULT_RESERVED;
      end
    endcase
  end

  assign res_o.operation     = op;
  assign res_o.fault_kind    = fault;
  assign res_o.fault_unit    = unit;
  assign res_o.illegal_quiet = quiet;
  assign res_o.source_reg    = rs;
  assign res_o.target_reg    = rt;
  assign res_o.dest_reg      = word_i[15:11];
  assign res_o.shift_amount  = word_i[10:6];
  assign res_o.immediate     = word_i[15:0];
  assign res_o.jump_target   = word_i[25:0];
endmodule

// File: hdl/mips3_instruction_decoder.sv
// Channel   Dir  Payload            Accepted when
// in_ch     in   instruction_word   valid && ready
// out_ch    out  decoded fields     valid && ready
// cfg       in   cop2/cop3 enables  cfg_we_i
//
// One item per cycle while the output is not stalled; each result is
// decoded between the input and result registers.
// Reset clears valids and both enables.
// Each stage advances when the one after it is empty or draining, so
// stalls on the output back up one stage at a time with no bubbles.
module mips3_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  mips3_dec_in_if.sink    in_ch,
  mips3_dec_out_if.source out_ch
);
  logic                    in_vld_q;
  logic [31:0]             in_word_q;
  logic                    out_vld_q;
  mips3_dec_pkg::dec_out_t out_q;
  mips3_dec_pkg::dec_out_t res_d;
  logic                    cop2_q;
  logic                    cop3_q;
  logic                    out_adv;
  logic                    in_adv;

  assign out_adv     = !out_vld_q || out_ch.ready;
  assign in_adv      = !in_vld_q || out_adv;
  assign in_ch.ready = in_adv;

  // configuration enables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cop2_q <= 1'b0;
      cop3_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mips3_dec_pkg::CFG_COP2) cop2_q <= cfg_data_i;
      if (cfg_idx_i == mips3_dec_pkg::CFG_COP3) cop3_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_ch.valid) in_word_q <= in_ch.payload.instruction_word;
  end

  mips3_dec_logic u_logic (
    .word_i        (in_word_q),
    .cop2_usable_i (cop2_q),
    .cop3_usable_i (cop3_q),
    .res_o         (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) out_q <= res_d;
  end

  assign out_ch.valid   = out_vld_q;
  assign out_ch.payload = out_q;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ch.ready |=> out_vld_q && $stable(out_q))
    else $error("result changed while stalled");
  // a full input stage behind a stalled output blocks new items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline full");
  // an unusable fault always names coprocessor 2 or 3
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.fault_kind == mips3_dec_pkg::FAULT_COP_UNUS
      |-> out_q.fault_unit[1])
    else $error("bad fault unit");
  // quiet flag and a fault never appear together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.illegal_quiet |-> out_q.fault_kind == mips3_dec_pkg::FAULT_NONE
      && out_q.operation == 8'd0)
    else $error("quiet flag with fault");
endmodule
